@@ rtl/prtt_pkg.sv @@
// Shared types and constants for the pending request tag table.
// No dependencies; used by the core, the slot store and the sequencer.
package prtt_pkg;

    // Operation codes carried on the func field
    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_MATCH   = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;
    localparam logic [1:0] FUNC_READ    = 2'd3;

    localparam int          TAG_W    = 32;
    localparam int          ID_W     = 31;
    localparam int          SLOT_W   = 3;
    localparam logic [30:0] ID_FIRST = 31'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FETCH,
        ST_CAPT,
        ST_RESP
    } state_t;

    // Write controls from the sequencer to the slot store
    typedef struct packed {
        logic wr_en;   // write tag, dst, src and size at wr_addr, mark slot busy
        logic clr_en;  // free the slot at wr_addr
    } store_ctl_t;

endpackage

@@ rtl/pending_request_tag_table_core.sv @@
// Pending request tag table: SLOTS slots of outstanding requests. Allocate
// claims the lowest free slot with the rolling 31-bit id, match overwrites the
// lowest slot whose tag equals the returned tag masked to 31 bits, release
// frees a slot and read reports it; each request gives exactly one result.
// One request is in the block at a time: s_ready is high only while idle and
// drops from acceptance until the result transfer. Allocate and match scan the
// tag memory one slot per cycle through its single read port and a shared
// comparator; a hit goes through the write state to the result, and a full
// table or missing tag gives the result after the last compare. In-range
// release and read go through fetch and capture. No clearing pass after reset.
// Depends on prtt_pkg, prtt_store and prtt_seq.
module pending_request_tag_table_core #(
    parameter int SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [2:0]  s_slot,
    input  logic [31:0] s_tag_in,
    input  logic [31:0] s_dst_in,
    input  logic [31:0] s_src_in,
    input  logic [31:0] s_size_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [2:0]  m_slot_out,
    output logic [31:0] m_entry_tag,
    output logic [31:0] m_entry_dst,
    output logic [31:0] m_entry_src,
    output logic [31:0] m_entry_size
);

    localparam int AW = $clog2(SLOTS);

    prtt_pkg::store_ctl_t       ctl;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic [prtt_pkg::TAG_W-1:0] wr_tag;
    logic [prtt_pkg::TAG_W-1:0] rd_tag;
    logic [31:0]                wr_dst, wr_src, wr_size;
    logic [31:0]                rd_dst, rd_src, rd_size;

    // Sequencer with shared tag comparator
    prtt_seq #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_slot       (s_slot),
        .s_tag_in     (s_tag_in),
        .s_dst_in     (s_dst_in),
        .s_src_in     (s_src_in),
        .s_size_in    (s_size_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ok         (m_ok),
        .m_slot_out   (m_slot_out),
        .m_entry_tag  (m_entry_tag),
        .m_entry_dst  (m_entry_dst),
        .m_entry_src  (m_entry_src),
        .m_entry_size (m_entry_size),
        .ctl          (ctl),
        .wr_addr      (wr_addr),
        .wr_tag       (wr_tag),
        .wr_dst       (wr_dst),
        .wr_src       (wr_src),
        .wr_size      (wr_size),
        .rd_addr      (rd_addr),
        .rd_tag       (rd_tag),
        .rd_dst       (rd_dst),
        .rd_src       (rd_src),
        .rd_size      (rd_size)
    );

    // Slot memories; payload words written from the captured request
    prtt_store #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .wr_tag  (wr_tag),
        .wr_dst  (wr_dst),
        .wr_src  (wr_src),
        .wr_size (wr_size),
        .rd_addr (rd_addr),
        .rd_tag  (rd_tag),
        .rd_dst  (rd_dst),
        .rd_src  (rd_src),
        .rd_size (rd_size)
    );

endmodule

@@ rtl/prtt_store.sv @@
// Slot store: tag, dst, src and size memories with one write and one read port.
// Tag entries carry a busy bit so that a slot never written reads as free.
// Depends on prtt_pkg.
module prtt_store #(
    parameter int SLOTS = 8,
    parameter int AW    = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  prtt_pkg::store_ctl_t       ctl,
    input  logic [AW-1:0]              wr_addr,
    input  logic [prtt_pkg::TAG_W-1:0] wr_tag,
    input  logic [31:0]                wr_dst,
    input  logic [31:0]                wr_src,
    input  logic [31:0]                wr_size,
    input  logic [AW-1:0]              rd_addr,
    output logic [prtt_pkg::TAG_W-1:0] rd_tag,
    output logic [31:0]                rd_dst,
    output logic [31:0]                rd_src,
    output logic [31:0]                rd_size
);

    logic [prtt_pkg::TAG_W-1:0] tag_mem  [SLOTS];
    logic [31:0]                dst_mem  [SLOTS];
    logic [31:0]                src_mem  [SLOTS];
    logic [31:0]                size_mem [SLOTS];
    logic [SLOTS-1:0]           busy_reg;
    logic                       busy_q_reg;
    logic [prtt_pkg::TAG_W-1:0] tag_q_reg;

    // Write and registered read of the payload memories
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            tag_mem[wr_addr]  <= wr_tag;
            dst_mem[wr_addr]  <= wr_dst;
            src_mem[wr_addr]  <= wr_src;
            size_mem[wr_addr] <= wr_size;
        end
        tag_q_reg <= tag_mem[rd_addr];
        rd_dst    <= dst_mem[rd_addr];
        rd_src    <= src_mem[rd_addr];
        rd_size   <= size_mem[rd_addr];
    end

    // Track busy slots; reset frees them all
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= '0;
            busy_q_reg <= 1'b0;
        end else begin
            if (ctl.wr_en) begin
                busy_reg[wr_addr] <= 1'b1;
            end else if (ctl.clr_en) begin
                busy_reg[wr_addr] <= 1'b0;
            end
            busy_q_reg <= busy_reg[rd_addr];
        end
    end

    // A free slot reads as a zero tag
    assign rd_tag = busy_q_reg ? tag_q_reg : '0;

endmodule

@@ rtl/prtt_seq.sv @@
// Sequencer: takes one request, scans the tag store one slot per cycle through
// a shared comparator, updates the hit slot and holds the result.
// Depends on prtt_pkg.
module prtt_seq #(
    parameter int SLOTS = 8,
    parameter int AW    = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request side
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [2:0]                 s_slot,
    input  logic [31:0]                s_tag_in,
    input  logic [31:0]                s_dst_in,
    input  logic [31:0]                s_src_in,
    input  logic [31:0]                s_size_in,
    // result side
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_ok,
    output logic [2:0]                 m_slot_out,
    output logic [31:0]                m_entry_tag,
    output logic [31:0]                m_entry_dst,
    output logic [31:0]                m_entry_src,
    output logic [31:0]                m_entry_size,
    // store side
    output prtt_pkg::store_ctl_t       ctl,
    output logic [AW-1:0]              wr_addr,
    output logic [prtt_pkg::TAG_W-1:0] wr_tag,
    output logic [31:0]                wr_dst,
    output logic [31:0]                wr_src,
    output logic [31:0]                wr_size,
    output logic [AW-1:0]              rd_addr,
    input  logic [prtt_pkg::TAG_W-1:0] rd_tag,
    input  logic [31:0]                rd_dst,
    input  logic [31:0]                rd_src,
    input  logic [31:0]                rd_size
);

    localparam logic [AW:0] SCAN_END = (AW + 1)'(SLOTS);

    prtt_pkg::state_t          state_reg, state_next;
    logic [1:0]                func_reg;
    logic [AW-1:0]             addr_reg;
    logic [31:0]               tag_reg, dst_reg, src_reg, size_reg;
    logic [31:0]               key_reg;
    logic [prtt_pkg::ID_W-1:0] id_reg, id_next, id_inc;
    logic [AW:0]               idx_reg, idx_next;
    logic                      pend_reg, pend_next;
    logic [AW-1:0]             cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]             hit_idx_reg, hit_idx_next;
    logic                      hit;
    logic                      accept;
    logic                      res_ok_reg, res_ok_next;
    logic [2:0]                res_slot_reg, res_slot_next;
    logic [31:0]               res_tag_reg, res_tag_next;
    logic [31:0]               res_dst_reg, res_dst_next;
    logic [31:0]               res_src_reg, res_src_next;
    logic [31:0]               res_size_reg, res_size_next;

    assign accept = s_valid && s_ready;
    assign hit    = pend_reg && (rd_tag == key_reg);

    // Payload words go to the store from the captured request
    assign wr_dst  = dst_reg;
    assign wr_src  = src_reg;
    assign wr_size = size_reg;

    // Next id: increment modulo 2^31, skip zero
    assign id_inc = id_reg + 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            prtt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_func == prtt_pkg::FUNC_ALLOC || s_func == prtt_pkg::FUNC_MATCH) begin
                        state_next = prtt_pkg::ST_SCAN;
                    end else if (32'(s_slot) < SLOTS) begin
                        state_next = prtt_pkg::ST_FETCH;
                    end else begin
                        state_next = prtt_pkg::ST_RESP;
                    end
                end
            end
            prtt_pkg::ST_SCAN: begin
                if (hit) begin
                    state_next = prtt_pkg::ST_WRITE;
                end else if (idx_reg == SCAN_END) begin
                    state_next = prtt_pkg::ST_RESP;
                end
            end
            prtt_pkg::ST_WRITE: state_next = prtt_pkg::ST_RESP;
            prtt_pkg::ST_FETCH: state_next = prtt_pkg::ST_CAPT;
            prtt_pkg::ST_CAPT:  state_next = prtt_pkg::ST_RESP;
            prtt_pkg::ST_RESP: begin
                if (m_ready) begin
                    state_next = prtt_pkg::ST_IDLE;
                end
            end
            default: state_next = prtt_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        ctl           = '0;
        wr_addr       = hit_idx_reg;
        wr_tag        = (func_reg == prtt_pkg::FUNC_ALLOC) ? {1'b0, id_reg} : tag_reg;
        rd_addr       = addr_reg;
        id_next       = id_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        cmp_idx_next  = cmp_idx_reg;
        hit_idx_next  = hit_idx_reg;
        res_ok_next   = res_ok_reg;
        res_slot_next = res_slot_reg;
        res_tag_next  = res_tag_reg;
        res_dst_next  = res_dst_reg;
        res_src_next  = res_src_reg;
        res_size_next = res_size_reg;
        unique case (state_reg)
            prtt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    // start from an empty result; a miss leaves it so
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    res_ok_next   = 1'b0;
                    res_slot_next = '0;
                    res_tag_next  = '0;
                    res_dst_next  = '0;
                    res_src_next  = '0;
                    res_size_next = '0;
                end
            end
            prtt_pkg::ST_SCAN: begin
                rd_addr = idx_reg[AW-1:0];
                if (hit) begin
                    hit_idx_next = cmp_idx_reg;
                end else if (idx_reg != SCAN_END) begin
                    // issue the next slot, compare it once its registered tag returns
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
            end
            prtt_pkg::ST_WRITE: begin
                ctl.wr_en     = 1'b1;
                res_ok_next   = 1'b1;
                res_slot_next = 3'(hit_idx_reg);
                res_tag_next  = wr_tag;
                res_dst_next  = dst_reg;
                res_src_next  = src_reg;
                res_size_next = size_reg;
                if (func_reg == prtt_pkg::FUNC_ALLOC) begin
                    id_next = (id_inc == '0) ? prtt_pkg::ID_FIRST : id_inc;
                end
            end
            prtt_pkg::ST_FETCH: begin
                rd_addr = addr_reg;
            end
            prtt_pkg::ST_CAPT: begin
                wr_addr       = addr_reg;
                ctl.clr_en    = (func_reg == prtt_pkg::FUNC_RELEASE);
                res_ok_next   = 1'b1;
                res_slot_next = 3'(addr_reg);
                res_tag_next  = (func_reg == prtt_pkg::FUNC_RELEASE) ? '0 : rd_tag;
                res_dst_next  = rd_dst;
                res_src_next  = rd_src;
                res_size_next = rd_size;
            end
            prtt_pkg::ST_RESP: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign m_ok         = res_ok_reg;
    assign m_slot_out   = res_slot_reg;
    assign m_entry_tag  = res_tag_reg;
    assign m_entry_dst  = res_dst_reg;
    assign m_entry_src  = res_src_reg;
    assign m_entry_size = res_size_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prtt_pkg::ST_IDLE;
            id_reg    <= prtt_pkg::ID_FIRST;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            id_reg    <= id_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
        end
    end

    // Request capture and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            addr_reg <= AW'(s_slot);
            tag_reg  <= s_tag_in;
            dst_reg  <= s_dst_in;
            src_reg  <= s_src_in;
            size_reg <= s_size_in;
            key_reg  <= (s_func == prtt_pkg::FUNC_ALLOC) ? '0 : {1'b0, s_tag_in[30:0]};
        end
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        res_ok_reg   <= res_ok_next;
        res_slot_reg <= res_slot_next;
        res_tag_reg  <= res_tag_next;
        res_dst_reg  <= res_dst_next;
        res_src_reg  <= res_src_next;
        res_size_reg <= res_size_next;
    end

endmodule

@@ rtl/prtt_checker.sv @@
// Port-level checks for the pending request tag table, bound to the top level.
// Depends on pending_request_tag_table_core port names only.
module prtt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_ok,
    input logic [2:0]  m_slot_out,
    input logic [31:0] m_entry_tag
);

    // One request at a time: no new transfer while a result is shown
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while result pending");

    // An accepted request closes the input once it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input reopened right after a transfer");

    // A failed operation reports an empty result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_slot_out == 3'd0 && m_entry_tag == 32'd0))
        else $error("failed result carries data");

    // A delivered result is not shown again after its transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> !m_valid)
        else $error("extra result after transfer");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_entry_tag)))
        else $error("stalled result changed");

endmodule

bind pending_request_tag_table_core prtt_checker u_prtt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_ok        (m_ok),
    .m_slot_out  (m_slot_out),
    .m_entry_tag (m_entry_tag)
);
